### hdl/cht_pkg.sv
// Shared types, widths and constants of the chained hash table.
`timescale 1ns / 1ps

package cht_pkg;

    localparam int KEY_W           = 32;
    localparam int VAL_W           = 16;
    localparam int CFG_W           = 6;
    localparam int CNT_OUT_W       = 8;
    localparam int DIG_W           = 4;
    localparam int DIV_STEPS       = KEY_W / DIG_W;
    localparam int STEP_W          = $clog2(DIV_STEPS);
    localparam int CAPACITY_DEF    = 128;
    localparam int MAX_BUCKETS_DEF = 32;
    localparam int FIFO_DEPTH      = 2;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 6'd25;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_SEARCH = 1'b1
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } t_item;

    typedef struct packed {
        logic                   found;
        logic [VAL_W-1:0]       value;
        logic [CNT_OUT_W-1:0]   count;
        logic                   full;
    } t_result;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_DONE
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HEAD,
        BK_NODE
    } t_back_state;

endpackage

### hdl/cht_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cht_fifo.sv
// Small register FIFO used between the front end, the back end and the result port.
`timescale 1ns / 1ps

module cht_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cht_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_go;
    logic             rd_go;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_go     = i_wr_en && !o_full;
    assign rd_go     = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_go) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_go) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_go && !rd_go) begin
                r_count <= r_count + 1'b1;
            end else if (rd_go && !wr_go) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### hdl/cht_front.sv
// Front end: accepts an item and reduces its key to a bucket, four key bits a cycle.
`timescale 1ns / 1ps

module cht_front #(
    parameter int MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [cht_pkg::CFG_W-1:0]              i_bucket_count,
    input  logic                                   i_push,
    output logic                                   o_full,
    input  cht_pkg::t_item                         i_item,
    output logic                                   o_valid,
    input  logic                                   i_q_full,
    output cht_pkg::t_item                         o_item,
    output logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] o_bucket
);

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int DW = $clog2(MAX_BUCKETS + 1);

    cht_pkg::t_front_state          r_state;
    cht_pkg::t_front_state          n_state;
    cht_pkg::t_item                 r_item;
    logic [cht_pkg::KEY_W-1:0]      r_shift;
    logic [DW-1:0]                  r_rem;
    logic [cht_pkg::STEP_W-1:0]     r_step;
    logic [DW-1:0]                  divisor;
    logic [DW-1:0]                  n_rem;
    logic                           accept;

    // Zero acts as one bucket; too many saturates to the table size.
    always_comb begin
        if (i_bucket_count == '0) begin
            divisor = DW'(1);
        end else if (32'(i_bucket_count) > 32'(MAX_BUCKETS)) begin
            divisor = DW'(MAX_BUCKETS);
        end else begin
            divisor = DW'(i_bucket_count);
        end
    end

    // Restoring remainder, one digit of the key per cycle, MSB first.
    always_comb begin
        logic [DW:0]   t;
        logic [DW-1:0] rem_v;
        rem_v = r_rem;
        t     = '0;
        for (int i = 0; i < cht_pkg::DIG_W; i++) begin
            t = {rem_v, r_shift[cht_pkg::KEY_W-1-i]};
            if (t >= {1'b0, divisor}) begin
                t = t - {1'b0, divisor};
            end
            rem_v = t[DW-1:0];
        end
        n_rem = rem_v;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cht_pkg::FR_IDLE: begin
                if (i_push) begin
                    n_state = cht_pkg::FR_DIV;
                end
            end
            cht_pkg::FR_DIV: begin
                if (r_step == cht_pkg::STEP_W'(cht_pkg::DIV_STEPS - 1)) begin
                    n_state = cht_pkg::FR_DONE;
                end
            end
            cht_pkg::FR_DONE: begin
                if (!i_q_full) begin
                    n_state = i_push ? cht_pkg::FR_DIV : cht_pkg::FR_IDLE;
                end
            end
            default: n_state = cht_pkg::FR_IDLE;
        endcase
    end

    always_comb begin
        o_full  = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            cht_pkg::FR_IDLE: o_full = 1'b0;
            cht_pkg::FR_DIV:  o_full = 1'b1;
            cht_pkg::FR_DONE: begin
                o_valid = 1'b1;
                o_full  = i_q_full;
            end
            default: o_full = 1'b1;
        endcase
        accept = i_push && !o_full;
    end

    assign o_item   = r_item;
    assign o_bucket = BW'(r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cht_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item  <= i_item;
            r_shift <= i_item.key;
            r_rem   <= '0;
            r_step  <= '0;
        end else if (r_state == cht_pkg::FR_DIV) begin
            r_shift <= r_shift << cht_pkg::DIG_W;
            r_rem   <= n_rem;
            r_step  <= r_step + 1'b1;
        end
    end

endmodule

### hdl/cht_back.sv
// Back end: bucket head and node pool memories, insert and chain walk.
`timescale 1ns / 1ps

module cht_back #(
    parameter int CAPACITY    = cht_pkg::CAPACITY_DEF,
    parameter int MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  cht_pkg::t_item                         i_item,
    input  logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] i_bucket,
    input  logic                                   i_empty,
    output logic                                   o_pop,
    input  logic                                   i_res_full,
    output logic                                   o_res_push,
    output cht_pkg::t_result                       o_res
);

    localparam int IW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int BW     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int V_LO   = cht_pkg::KEY_W;
    localparam int L_LO   = V_LO + cht_pkg::VAL_W;
    localparam int LV_POS = L_LO + IW;
    localparam int B_LO   = LV_POS + 1;
    localparam int NW     = B_LO + BW;

    cht_pkg::t_back_state       r_state;
    cht_pkg::t_back_state       n_state;
    cht_pkg::t_func             r_func;
    cht_pkg::t_func             n_func;
    logic [cht_pkg::KEY_W-1:0]  r_key;
    logic [cht_pkg::KEY_W-1:0]  n_key;
    logic [cht_pkg::VAL_W-1:0]  r_value;
    logic [cht_pkg::VAL_W-1:0]  n_value;
    logic [BW-1:0]              r_bucket;
    logic [BW-1:0]              n_bucket;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [IW-1:0]              r_cur;
    logic [IW-1:0]              n_cur;
    logic                       r_first;
    logic                       n_first;
    logic                       r_ok;
    logic                       n_ok;

    logic [IW-1:0]              head_rd;
    logic                       head_we;
    logic [NW-1:0]              node_rd;
    logic [NW-1:0]              node_wdata;
    logic                       node_we;
    logic [IW-1:0]              node_raddr;

    logic [cht_pkg::KEY_W-1:0]  nd_key;
    logic [cht_pkg::VAL_W-1:0]  nd_value;
    logic [IW-1:0]              nd_link;
    logic                       nd_link_ok;
    logic [BW-1:0]              nd_bucket;
    logic                       head_ok;
    logic                       cur_ok;
    logic                       hit;
    logic                       pool_full;
    logic                       start;

    cht_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_BUCKETS)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (r_bucket),
        .i_wdata (IW'(r_count)),
        .i_raddr (i_bucket),
        .o_rdata (head_rd)
    );

    cht_ram #(
        .WIDTH (NW),
        .DEPTH (CAPACITY)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (IW'(r_count)),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rd)
    );

    assign nd_key     = node_rd[cht_pkg::KEY_W-1:0];
    assign nd_value   = node_rd[L_LO-1:V_LO];
    assign nd_link    = node_rd[LV_POS-1:L_LO];
    assign nd_link_ok = node_rd[LV_POS];
    assign nd_bucket  = node_rd[NW-1:B_LO];

    assign node_wdata = {r_bucket, head_ok, r_cur, r_value, r_key};
    assign pool_full  = (r_count >= CW'(CAPACITY));
    assign start      = !i_empty && !i_res_full;

    // Heads carry no valid bits: a head counts only if it names an allocated
    // node that was put into this same bucket. Nodes are never freed, so a
    // bucket that was never written cannot pass this test.
    always_comb begin
        head_ok = 1'b0;
        if ((CW'(r_cur) < r_count) && (nd_bucket == r_bucket)) begin
            head_ok = 1'b1;
        end
        cur_ok = r_ok;
        if (r_first) begin
            cur_ok = head_ok;
        end
        hit = (nd_key == r_key);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cht_pkg::BK_IDLE: begin
                if (start) begin
                    n_state = cht_pkg::BK_HEAD;
                end
            end
            cht_pkg::BK_HEAD: begin
                if (r_func == cht_pkg::FUNC_INSERT && pool_full) begin
                    n_state = cht_pkg::BK_IDLE;
                end else begin
                    n_state = cht_pkg::BK_NODE;
                end
            end
            cht_pkg::BK_NODE: begin
                if (r_func == cht_pkg::FUNC_INSERT || !cur_ok || hit) begin
                    n_state = cht_pkg::BK_IDLE;
                end
            end
            default: n_state = cht_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        head_we    = 1'b0;
        node_we    = 1'b0;
        node_raddr = head_rd;
        n_func     = r_func;
        n_key      = r_key;
        n_value    = r_value;
        n_bucket   = r_bucket;
        n_count    = r_count;
        n_cur      = r_cur;
        n_first    = r_first;
        n_ok       = r_ok;
        unique case (r_state)
            cht_pkg::BK_IDLE: begin
                o_pop = start;
                if (start) begin
                    n_func   = i_item.func;
                    n_key    = i_item.key;
                    n_value  = i_item.value;
                    n_bucket = i_bucket;
                end
            end
            cht_pkg::BK_HEAD: begin
                n_cur   = head_rd;
                n_first = 1'b1;
                if (r_func == cht_pkg::FUNC_INSERT && pool_full) begin
                    o_res_push  = 1'b1;
                    o_res.full  = 1'b1;
                    o_res.count = cht_pkg::CNT_OUT_W'(r_count);
                end
            end
            cht_pkg::BK_NODE: begin
                if (r_func == cht_pkg::FUNC_INSERT) begin
                    // push the new node in front of the old head
                    node_we     = 1'b1;
                    head_we     = 1'b1;
                    n_count     = r_count + 1'b1;
                    o_res_push  = 1'b1;
                    o_res.count = cht_pkg::CNT_OUT_W'(r_count + 1'b1);
                end else if (!cur_ok) begin
                    o_res_push  = 1'b1;
                    o_res.count = cht_pkg::CNT_OUT_W'(r_count);
                end else if (hit) begin
                    o_res_push  = 1'b1;
                    o_res.found = 1'b1;
                    o_res.value = nd_value;
                    o_res.count = cht_pkg::CNT_OUT_W'(r_count);
                end else begin
                    // advance to the next older node
                    n_cur      = nd_link;
                    n_ok       = nd_link_ok;
                    n_first    = 1'b0;
                    node_raddr = nd_link;
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cht_pkg::BK_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_key    <= n_key;
        r_value  <= n_value;
        r_bucket <= n_bucket;
        r_cur    <= n_cur;
        r_first  <= n_first;
        r_ok     <= n_ok;
    end

endmodule

### hdl/chained_hash_table.sv
// Top level of the chained hash table: config register, front end, queues, back end.
// Front end: 8 remainder steps of 4 key bits per item, then a hand-off state that can take the
// next item; none is taken while dividing. Back end: an insert reads the bucket head, then writes
// the node (refused at the head on a full pool); a search reads the head, then compares chain
// nodes until a hit or the chain end. A slow back end stalls the front end through the queue.
// Synchronous active-low reset empties the table and the queues and sets bucket_count to 25.
`timescale 1ns / 1ps

module chained_hash_table #(
    parameter int CAPACITY    = cht_pkg::CAPACITY_DEF,
    parameter int MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cht_pkg::CFG_W-1:0]       i_cfg_bucket_count,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_func,
    input  logic [cht_pkg::KEY_W-1:0]       i_key,
    input  logic [cht_pkg::VAL_W-1:0]       i_value_handle,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_found,
    output logic [cht_pkg::VAL_W-1:0]       o_result_value,
    output logic [cht_pkg::CNT_OUT_W-1:0]   o_item_count,
    output logic                            o_full_res
);

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int QW = $bits(cht_pkg::t_item) + BW;
    localparam int RW = $bits(cht_pkg::t_result);

    logic [cht_pkg::CFG_W-1:0]  r_bucket_count;
    cht_pkg::t_item             in_item;
    cht_pkg::t_item             fr_item;
    logic [BW-1:0]              fr_bucket;
    logic                       fr_valid;
    logic                       q_full;
    logic                       q_empty;
    logic [QW-1:0]              q_rd_data;
    logic                       q_pop;
    cht_pkg::t_item             bk_item;
    logic [BW-1:0]              bk_bucket;
    logic                       res_full;
    logic                       res_push;
    cht_pkg::t_result           bk_res;
    logic [RW-1:0]              res_rd_data;
    cht_pkg::t_result           out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= cht_pkg::BUCKET_COUNT_RST;
        end else if (i_cfg_valid) begin
            r_bucket_count <= i_cfg_bucket_count;
        end
    end

    assign in_item.func  = cht_pkg::t_func'(i_func);
    assign in_item.key   = i_key;
    assign in_item.value = i_value_handle;

    cht_front #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bucket_count (r_bucket_count),
        .i_push         (push),
        .o_full         (full),
        .i_item         (in_item),
        .o_valid        (fr_valid),
        .i_q_full       (q_full),
        .o_item         (fr_item),
        .o_bucket       (fr_bucket)
    );

    cht_fifo #(
        .WIDTH (QW),
        .DEPTH (cht_pkg::FIFO_DEPTH)
    ) u_work_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (fr_valid),
        .i_wr_data ({fr_item, fr_bucket}),
        .o_full    (q_full),
        .i_rd_en   (q_pop),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty)
    );

    assign bk_item   = q_rd_data[QW-1:BW];
    assign bk_bucket = q_rd_data[BW-1:0];

    cht_back #(
        .CAPACITY    (CAPACITY),
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (bk_item),
        .i_bucket   (bk_bucket),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (bk_res)
    );

    cht_fifo #(
        .WIDTH (RW),
        .DEPTH (cht_pkg::FIFO_DEPTH)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_push),
        .i_wr_data (bk_res),
        .o_full    (res_full),
        .i_rd_en   (pop),
        .o_rd_data (res_rd_data),
        .o_empty   (empty)
    );

    assign out_res        = res_rd_data;
    assign o_found        = out_res.found;
    assign o_result_value = out_res.value;
    assign o_item_count   = out_res.count;
    assign o_full_res     = out_res.full;

endmodule
